// ----- design/bfsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsa_pkg
// shared types, codes and constants of the frame slot allocator
// ----------------------------------------------------------------------------
package bfsa_pkg;

    localparam int MAX_SLOTS_DEF    = 16;
    localparam int MIN_SLOTS_DEF    = 2;
    localparam int HEADER_BYTES_DEF = 64;

    localparam int TOT_W  = 40;
    localparam int SIZE_W = 32;
    localparam int HOLD_W = 16;
    localparam logic [TOT_W-1:0] BUDGET_RESET = 40'd268435456;
    localparam logic [HOLD_W-1:0] HOLD_MAX = 16'hFFFF;

    localparam logic [1:0] MODE_ACQ     = 2'd0;
    localparam logic [1:0] MODE_ADD     = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;
    localparam logic [1:0] MODE_SHED    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSLOT = 2'd1;
    localparam logic [1:0] ST_BUDGET = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, clear scan state
        logic scan;      // examine slot at scan index
        logic decide;    // settle acquire choice
        logic commit;    // apply grant
        logic evict_scan;
        logic evict_drop;
        logic shed;      // drop free slot at scan index
        logic simple;    // add or release hold
        logic finish;    // present result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       scan_last;
        logic       reuse_hit;
        logic       over_budget;
        logic       refuse;  // acquire already answered
        logic       evict_found;
    } t_stat;

endpackage

// ----- design/budgeted_frame_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// budgeted_frame_slot_allocator_top
// frame buffer slot table under a byte budget
// ----------------------------------------------------------------------------
// channel   | handshake                     | payload
// request   | i_start / o_busy              | i_mode, i_byte_count, i_slot_number
// result    | o_done (one-cycle strobe)     | o_status .. o_allocated_total
// config    | psel/penable/pwrite/pready    | 40-bit budget limit at address 0
//
// acquire: scan the slots in use (stopping early on a reuse hit), decide, commit, then
//   eviction passes (scan, drop) while over budget and a free buffer is found, then done
// a refused acquire goes to done from scan (zero bytes) or from commit (no slot, budget)
// shed: one sweep of the slots in use, then done; add and release hold: done only
// result strobe in the cycle in which busy drops; results cannot be stalled
// synchronous reset clears the table and restores the budget limit
module budgeted_frame_slot_allocator_top #(
    parameter int MAX_SLOTS    = bfsa_pkg::MAX_SLOTS_DEF,
    parameter int MIN_SLOTS    = bfsa_pkg::MIN_SLOTS_DEF,
    parameter int HEADER_BYTES = bfsa_pkg::HEADER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_byte_count,
    input  logic [3:0]  i_slot_number,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [3:0]  o_granted_slot,
    output logic [31:0] o_acquisition_id,
    output logic [31:0] o_buffer_id,
    output logic        o_slot_freed,
    output logic [39:0] o_allocated_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int ADDR_BUDGET = 0;

    bfsa_pkg::t_cmd  w_cmd;
    bfsa_pkg::t_stat w_stat;
    logic [bfsa_pkg::TOT_W-1:0] r_budget;
    logic w_pwr;

    assign pready = 1'b1;
    assign w_pwr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_budget <= bfsa_pkg::BUDGET_RESET;
        else if (w_pwr && paddr == 1'(ADDR_BUDGET)) r_budget <= pwdata[bfsa_pkg::TOT_W-1:0];
    end

    assign prdata = (paddr == 1'(ADDR_BUDGET)) ? {24'd0, r_budget} : '0;

    bfsa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_mode(i_mode),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(o_busy)
    );

    bfsa_dp #(
        .MAX_SLOTS(MAX_SLOTS), .MIN_SLOTS(MIN_SLOTS), .HEADER_BYTES(HEADER_BYTES)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_mode(i_mode), .i_byte_count(i_byte_count), .i_slot_number(i_slot_number),
        .i_budget(r_budget), .o_done(o_done), .o_status(o_status),
        .o_granted_slot(o_granted_slot), .o_acquisition_id(o_acquisition_id),
        .o_buffer_id(o_buffer_id), .o_slot_freed(o_slot_freed),
        .o_allocated_total(o_allocated_total)
    );

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("result strobe while busy");
    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_slot_freed |-> o_status == bfsa_pkg::ST_OK)
        else $error("slot freed on failed request");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy) else $error("request not taken");

endmodule

// ----- design/bfsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfsa_ctrl
// sequencer: scan, decide, commit, evict passes, shed sweep
// ----------------------------------------------------------------------------
module bfsa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_mode,
    input  bfsa_pkg::t_stat i_stat,
    output bfsa_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_COMM  = 3'd3;
    localparam logic [2:0] S_ESCAN = 3'd4;
    localparam logic [2:0] S_EDROP = 3'd5;
    localparam logic [2:0] S_SHED  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        bfsa_pkg::MODE_ACQ:  n_state = S_SCAN;
                        bfsa_pkg::MODE_SHED: n_state = S_SHED;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.refuse) n_state = S_DONE;
                else if (i_stat.scan_last || i_stat.reuse_hit) n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state = S_COMM;
            end
            S_COMM: begin
                if (i_stat.refuse) n_state = S_DONE;
                else begin
                    o_cmd.commit = 1'b1;
                    n_state = S_ESCAN;
                end
            end
            S_ESCAN: begin
                if (!i_stat.over_budget) n_state = S_DONE;
                else begin
                    o_cmd.evict_scan = 1'b1;
                    if (i_stat.scan_last) n_state = S_EDROP;
                end
            end
            S_EDROP: begin
                o_cmd.evict_drop = 1'b1;
                n_state = i_stat.evict_found ? S_ESCAN : S_DONE;
            end
            S_SHED: begin
                o_cmd.shed = 1'b1;
                if (i_stat.scan_last) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.simple = 1'b1;
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- design/bfsa_dp.sv -----
// ----------------------------------------------------------------------------
// bfsa_dp
// slot table registers, one slot examined per cycle
// ----------------------------------------------------------------------------
module bfsa_dp #(
    parameter int MAX_SLOTS    = bfsa_pkg::MAX_SLOTS_DEF,
    parameter int MIN_SLOTS    = bfsa_pkg::MIN_SLOTS_DEF,
    parameter int HEADER_BYTES = bfsa_pkg::HEADER_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bfsa_pkg::t_cmd           i_cmd,
    output bfsa_pkg::t_stat          o_stat,
    input  logic [1:0]               i_mode,
    input  logic [31:0]              i_byte_count,
    input  logic [3:0]               i_slot_number,
    input  logic [bfsa_pkg::TOT_W-1:0] i_budget,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic [3:0]               o_granted_slot,
    output logic [31:0]              o_acquisition_id,
    output logic [31:0]              o_buffer_id,
    output logic                     o_slot_freed,
    output logic [bfsa_pkg::TOT_W-1:0] o_allocated_total
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int TW = bfsa_pkg::TOT_W;
    localparam logic [TW-1:0] HDR = TW'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SLOTS);
    localparam logic [CW-1:0] MINC = CW'(MIN_SLOTS);

    logic [CW-1:0]               r_used;
    logic [bfsa_pkg::HOLD_W-1:0] r_hold [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]        r_pres;
    logic [31:0]                 r_size [MAX_SLOTS];
    logic [31:0]                 r_acq  [MAX_SLOTS];
    logic [31:0]                 r_gen  [MAX_SLOTS];
    logic [TW-1:0]               r_total;
    logic                        r_shed_rel;

    logic [1:0]    r_mode;
    logic [31:0]   r_bytes;
    logic [3:0]    r_sn;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_chosen;
    logic          r_have_free, r_reuse, r_refuse, r_found;
    logic [CW-1:0] r_held;
    logic [1:0]    r_status;
    logic [TW-1:0] r_best;

    logic [31:0] sz_i;
    logic        free_i, last_i, in_tab;
    logic [TW-1:0] cost_i, cost_ch;

    assign sz_i   = r_size[r_idx];
    assign free_i = (r_hold[r_idx] == '0);
    assign cost_i = r_pres[r_idx] ? ({8'd0, sz_i} + HDR) : '0;
    assign cost_ch = r_pres[r_chosen] ? ({8'd0, r_size[r_chosen]} + HDR) : '0;
    assign last_i = ({1'b0, r_idx} + CW'(1) >= r_used) || (r_used == '0);
    assign in_tab = ({1'b0, r_sn} < {1'b0, r_used});

    assign o_stat.scan_last   = last_i;
    assign o_stat.reuse_hit   = r_reuse;
    assign o_stat.over_budget = r_total > i_budget;
    assign o_stat.refuse      = r_refuse;
    assign o_stat.evict_found = r_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_pres <= '0;
            r_total <= '0;
            r_shed_rel <= 1'b0;
            o_done <= 1'b0;
            for (int s = 0; s < MAX_SLOTS; s++) begin
                r_hold[s] <= '0;
                r_acq[s]  <= '0;
                r_gen[s]  <= '0;
            end
        end else begin
            o_done <= i_cmd.finish;
            if (i_cmd.load) begin
                r_mode <= i_mode; r_bytes <= i_byte_count; r_sn <= i_slot_number;
                r_idx <= '0; r_chosen <= '0; r_have_free <= 1'b0;
                r_reuse <= 1'b0; r_held <= '0; r_found <= 1'b0; r_best <= '0;
                r_status <= bfsa_pkg::ST_OK;
                r_refuse <= (i_mode == bfsa_pkg::MODE_ACQ) && (i_byte_count == '0);
                if ((i_mode == bfsa_pkg::MODE_ACQ) && (i_byte_count == '0))
                    r_status <= bfsa_pkg::ST_BAD;
                if (i_mode == bfsa_pkg::MODE_SHED) r_shed_rel <= 1'b1;
                o_granted_slot <= '0; o_acquisition_id <= '0;
                o_buffer_id <= '0; o_slot_freed <= 1'b0;
            end
            // the scan stops at the first exact-size free slot
            if (i_cmd.scan && !r_refuse && !r_reuse) begin
                if (r_used != '0) begin
                    if (!free_i) r_held <= r_held + CW'(1);
                    if (free_i && !r_have_free) begin
                        r_chosen <= r_idx; r_have_free <= 1'b1;
                    end
                    if (free_i && r_pres[r_idx] && sz_i == r_bytes) begin
                        r_chosen <= r_idx; r_reuse <= 1'b1;
                    end
                end
                if (!last_i) r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.decide && !r_reuse) begin
                if (!r_have_free) begin
                    if (r_used >= MAXC) begin
                        r_refuse <= 1'b1; r_status <= bfsa_pkg::ST_NOSLOT;
                    end else begin
                        r_chosen <= r_used[IW-1:0];
                        r_used <= r_used + CW'(1);
                        if (r_total + {8'd0, r_bytes} + HDR > i_budget && r_held >= MINC) begin
                            r_refuse <= 1'b1; r_status <= bfsa_pkg::ST_BUDGET;
                        end
                    end
                end else if (r_total - cost_ch + {8'd0, r_bytes} + HDR > i_budget
                             && r_held >= MINC) begin
                    r_refuse <= 1'b1; r_status <= bfsa_pkg::ST_BUDGET;
                end
            end
            if (i_cmd.commit) begin
                if (!r_reuse) begin
                    r_pres[r_chosen] <= 1'b1;
                    r_size[r_chosen] <= r_bytes;
                    r_gen[r_chosen]  <= r_gen[r_chosen] + 32'd1;
                    r_total <= r_total - cost_ch + {8'd0, r_bytes} + HDR;
                    o_buffer_id <= r_gen[r_chosen] + 32'd1;
                end else o_buffer_id <= r_gen[r_chosen];
                r_shed_rel <= 1'b0;
                r_hold[r_chosen] <= bfsa_pkg::HOLD_W'(1);
                r_acq[r_chosen] <= r_acq[r_chosen] + 32'd1;
                o_acquisition_id <= r_acq[r_chosen] + 32'd1;
                o_granted_slot <= 4'(r_chosen);
                r_idx <= '0; r_found <= 1'b0; r_best <= '0;
            end
            // largest free buffer, lowest slot on ties
            if (i_cmd.evict_scan) begin
                if (free_i && r_pres[r_idx] && (!r_found || cost_i > r_best)) begin
                    r_found <= 1'b1; r_best <= cost_i; r_chosen <= r_idx;
                end
                if (!last_i) r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.evict_drop) begin
                if (r_found) begin
                    r_pres[r_chosen] <= 1'b0;
                    r_total <= r_total - cost_ch;
                end
                r_idx <= '0; r_found <= 1'b0; r_best <= '0;
            end
            if (i_cmd.shed) begin
                if (r_used != '0 && free_i && r_pres[r_idx]) begin
                    r_pres[r_idx] <= 1'b0;
                    r_total <= r_total - cost_i;
                end
                if (!last_i) r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.simple) begin
                if (r_mode == bfsa_pkg::MODE_ADD) begin
                    if (!in_tab || r_hold[IW'(r_sn)] == '0
                        || r_hold[IW'(r_sn)] >= bfsa_pkg::HOLD_MAX)
                        r_status <= bfsa_pkg::ST_BAD;
                    else r_hold[IW'(r_sn)] <= r_hold[IW'(r_sn)] + 16'd1;
                end else if (r_mode == bfsa_pkg::MODE_RELEASE) begin
                    if (!in_tab || r_hold[IW'(r_sn)] == '0)
                        r_status <= bfsa_pkg::ST_BAD;
                    else begin
                        r_hold[IW'(r_sn)] <= r_hold[IW'(r_sn)] - 16'd1;
                        if (r_hold[IW'(r_sn)] == 16'd1) begin
                            o_slot_freed <= 1'b1;
                            if (r_shed_rel && r_pres[IW'(r_sn)]) begin
                                r_pres[IW'(r_sn)] <= 1'b0;
                                r_total <= r_total - ({8'd0, r_size[IW'(r_sn)]} + HDR);
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        o_status = r_status;
        o_allocated_total = r_total;
    end

endmodule

// ----- bench/budgeted_frame_slot_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// budgeted_frame_slot_allocator_top_tb
// self-checking bench for the budgeted frame slot allocator: directed cases,
// then random request streams under several budgets and idle patterns; each
// result strobe is compared against a slot table tracked alongside the block
// ----------------------------------------------------------------------------
module budgeted_frame_slot_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = bfsa_pkg::MAX_SLOTS_DEF;
    localparam int HDR   = bfsa_pkg::HEADER_BYTES_DEF;
    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] acq_id;
        logic [31:0] buf_id;
        logic        freed;
        logic [39:0] total;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_mode;
    logic [31:0] i_byte_count;
    logic [3:0]  i_slot_number;
    logic        o_done;
    logic [1:0]  o_status;
    logic [3:0]  o_granted_slot;
    logic [31:0] o_acquisition_id;
    logic [31:0] o_buffer_id;
    logic        o_slot_freed;
    logic [39:0] o_allocated_total;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    budgeted_frame_slot_allocator_top uut (.*);

    // tracked slot table
    logic [39:0] budget;
    int          used;
    logic [15:0] holds   [NSLOT];
    logic        present [NSLOT];
    logic [31:0] psize   [NSLOT];
    logic [31:0] acq_cnt [NSLOT];
    logic [31:0] gen_cnt [NSLOT];
    logic [39:0] total;
    logic        shed_pending;

    t_grant expected_q[$];
    int     errors;
    int     cycles;
    logic   busy_s;
    int     send_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) busy_s <= o_busy;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [39:0] cost(int s);
        return present[s] ? {8'd0, psize[s]} + HDR : 40'd0;
    endfunction

    function automatic void drop(int s);
        if (present[s]) begin
            total = total - cost(s);
            present[s] = 1'b0;
        end
    endfunction

    function automatic void evict_over_budget();
        int pick;
        bit found;
        while (total > budget) begin
            found = 0;
            pick = 0;
            for (int s = 0; s < used; s++) begin
                if (holds[s] == 0 && present[s] && (!found || cost(s) > cost(pick))) begin
                    pick = s;
                    found = 1;
                end
            end
            if (!found) break;
            drop(pick);
        end
    endfunction

    function automatic t_grant predict_slot_table(logic [1:0] md, logic [31:0] nb,
                                                  logic [3:0] sn);
        t_grant r;
        int chosen;
        int held;
        bit have_free;
        bit reuse;
        logic [63:0] after;
        r = '0;
        r.status = bfsa_pkg::ST_OK;
        case (md)
            bfsa_pkg::MODE_ACQ: begin
                chosen = 0;
                have_free = 0;
                reuse = 0;
                if (nb == 0) begin
                    r.status = bfsa_pkg::ST_BAD;
                end else begin
                    for (int s = 0; s < used; s++) begin
                        if (holds[s] != 0) continue;
                        if (!have_free) begin
                            chosen = s;
                            have_free = 1;
                        end
                        if (present[s] && psize[s] == nb) begin
                            chosen = s;
                            reuse = 1;
                            break;
                        end
                    end
                    if (!reuse && !have_free) begin
                        if (used >= NSLOT) r.status = bfsa_pkg::ST_NOSLOT;
                        else begin
                            chosen = used;
                            used++;
                        end
                    end
                    if (!reuse && r.status == bfsa_pkg::ST_OK) begin
                        held = 0;
                        for (int s = 0; s < used; s++) held += (holds[s] != 0);
                        after = {24'd0, total} - cost(chosen) + nb + HDR;
                        if (after > {24'd0, budget} && held >= bfsa_pkg::MIN_SLOTS_DEF) begin
                            r.status = bfsa_pkg::ST_BUDGET;
                        end else begin
                            drop(chosen);
                            present[chosen] = 1'b1;
                            psize[chosen] = nb;
                            gen_cnt[chosen]++;
                            total = total + nb + HDR;
                        end
                    end
                    if (r.status == bfsa_pkg::ST_OK) begin
                        shed_pending = 1'b0;
                        holds[chosen] = 1;
                        acq_cnt[chosen]++;
                        evict_over_budget();
                        r.slot = chosen[3:0];
                        r.acq_id = acq_cnt[chosen];
                        r.buf_id = gen_cnt[chosen];
                    end
                end
            end
            bfsa_pkg::MODE_ADD: begin
                if (sn >= used || holds[sn] == 0 || holds[sn] == bfsa_pkg::HOLD_MAX)
                    r.status = bfsa_pkg::ST_BAD;
                else holds[sn]++;
            end
            bfsa_pkg::MODE_RELEASE: begin
                if (sn >= used || holds[sn] == 0) begin
                    r.status = bfsa_pkg::ST_BAD;
                end else begin
                    holds[sn]--;
                    if (holds[sn] == 0) begin
                        if (shed_pending) drop(sn);
                        r.freed = 1'b1;
                    end
                end
            end
            default: begin
                shed_pending = 1'b1;
                for (int s = 0; s < used; s++)
                    if (holds[s] == 0) drop(s);
            end
        endcase
        r.total = total;
        return r;
    endfunction

    // result checker
    always @(negedge i_clk) begin
        t_grant got;
        t_grant want;
        if (i_rst_n && o_done) begin
            got = '{o_status, o_granted_slot, o_acquisition_id, o_buffer_id,
                    o_slot_freed, o_allocated_total};
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp st=%0d sl=%0d acq=%h buf=%h fr=%b tot=%h",
                                  " | got st=%0d sl=%0d acq=%h buf=%h fr=%b tot=%h"},
                                 want.status, want.slot, want.acq_id, want.buf_id,
                                 want.freed, want.total, got.status, got.slot,
                                 got.acq_id, got.buf_id, got.freed, got.total);
                end
            end
        end
    end

    task automatic send_request(logic [1:0] md, logic [31:0] nb, logic [3:0] sn);
        int gap;
        gap = ($urandom_range(0, 99) < send_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_mode        <= md;
        i_byte_count  <= nb;
        i_slot_number <= sn;
        do @(posedge i_clk); while (busy_s);
        expected_q.push_back(predict_slot_table(md, nb, sn));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (expected_q.size() != 0 || busy_s) @(posedge i_clk);
        // shed and rejected requests still answer, so a short settle suffices
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_budget(logic [39:0] v);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        budget = v;
    endtask

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 32'd64 << $urandom_range(0, 4);
            4, 5:       return $urandom_range(1, 4096);
            6:          return 32'hFFFF_FFFF - $urandom_range(0, 3);
            7:          return $urandom_range(0, 3);
            default:    return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_request(bfsa_pkg::MODE_ACQ, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_ADD, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_RELEASE, 32'd0, 4'd15);
        send_request(bfsa_pkg::MODE_ACQ, 32'd100, 4'd0);
        send_request(bfsa_pkg::MODE_ACQ, 32'hFFFF_FFFF, 4'd0);
        send_request(bfsa_pkg::MODE_ADD, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_RELEASE, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_RELEASE, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_ACQ, 32'd100, 4'd0);
        send_request(bfsa_pkg::MODE_RELEASE, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_SHED, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_RELEASE, 32'd0, 4'd1);
        send_request(bfsa_pkg::MODE_RELEASE, 32'd0, 4'd1);
        send_request(bfsa_pkg::MODE_ACQ, 32'd500, 4'd0);
        send_request(bfsa_pkg::MODE_ACQ, 32'd600, 4'd0);
        send_request(bfsa_pkg::MODE_ACQ, 32'd700, 4'd0);
    endtask

    task automatic test_table_full();
        for (int k = 0; k < NSLOT + 2; k++)
            send_request(bfsa_pkg::MODE_ACQ, 32'd32 + k, 4'd0);
        send_request(bfsa_pkg::MODE_ADD, 32'd0, 4'd15);
        for (int k = 0; k < NSLOT; k++) send_request(bfsa_pkg::MODE_RELEASE, 32'd0, k[3:0]);
        send_request(bfsa_pkg::MODE_SHED, 32'd0, 4'd0);
    endtask

    task automatic test_hold_counting();
        send_request(bfsa_pkg::MODE_ACQ, 32'd8, 4'd0);
        for (int k = 0; k < 20; k++) send_request(bfsa_pkg::MODE_ADD, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_RELEASE, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_ADD, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_ADD, 32'd0, 4'd0);
        while (holds[0] != 0) send_request(bfsa_pkg::MODE_RELEASE, 32'd0, 4'd0);
    endtask

    task automatic test_budget_limits();
        write_budget(40'd300);
        for (int k = 0; k < 6; k++) send_request(bfsa_pkg::MODE_ACQ, 32'd100 + k, 4'd0);
        send_request(bfsa_pkg::MODE_RELEASE, 32'd0, 4'd0);
        send_request(bfsa_pkg::MODE_ACQ, 32'd4000, 4'd0);
        write_budget(40'd0);
        for (int k = 0; k < 4; k++) send_request(bfsa_pkg::MODE_RELEASE, 32'd0, k[3:0]);
        send_request(bfsa_pkg::MODE_ACQ, 32'd1, 4'd0);
        send_request(bfsa_pkg::MODE_ACQ, 32'd1, 4'd0);
        write_budget(40'h00_FFFF_FFFF);
        send_request(bfsa_pkg::MODE_ACQ, 32'hFFFF_FFFF, 4'd0);
        send_request(bfsa_pkg::MODE_SHED, 32'd0, 4'd0);
    endtask

    task automatic test_random(int n);
        logic [3:0] sn;
        for (int k = 0; k < n; k++) begin
            sn = 4'((used > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, used - 1)
                                                            : $urandom_range(0, 15));
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: send_request(bfsa_pkg::MODE_ACQ, pick_size(), sn);
                8, 9:                   send_request(bfsa_pkg::MODE_ADD, $urandom(), sn);
                18:                     send_request(bfsa_pkg::MODE_SHED, $urandom(), sn);
                19:                     send_request(2'($urandom_range(0, 3)), $urandom(),
                                                     4'($urandom()));
                default:                send_request(bfsa_pkg::MODE_RELEASE, $urandom(), sn);
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_mode = bfsa_pkg::MODE_ACQ;
        i_byte_count = '0;
        i_slot_number = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        send_pct = 0;
        budget = bfsa_pkg::BUDGET_RESET;
        used = 0;
        total = '0;
        shed_pending = 1'b0;
        for (int s = 0; s < NSLOT; s++) begin
            holds[s] = '0;
            present[s] = 1'b0;
            psize[s] = '0;
            acq_cnt[s] = '0;
            gen_cnt[s] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_table_full();
        test_hold_counting();
        test_budget_limits();

        write_budget(40'd20000);
        send_pct = 0;
        test_random(80);
        write_budget(40'd2000);
        send_pct = 64;
        test_random(60);
        write_budget(40'hFF_FFFF_FFFF);
        send_pct = 12;
        test_random(60);
        write_budget(40'd0);
        send_pct = 0;
        test_random(30);
        write_budget(40'h00_1000_0000);
        send_pct = 64;
        test_random(50);

        drain();
        repeat (400) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/bfsa_pkg.sv
design/bfsa_ctrl.sv
design/bfsa_dp.sv
design/budgeted_frame_slot_allocator_top.sv
bench/budgeted_frame_slot_allocator_top_tb.sv
